FILE: design/nscs_pkg.sv
package nscs_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SENT,
      PH_CHK_HI,
      PH_CHK_LO
   } nscs_phase_type;

   // result kinds
   localparam logic KIND_FIELD   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NONPRINT = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // characters of interest
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] PRINT_LOW   = 8'd32;
   localparam logic [7:0] PRINT_HIGH  = 8'd126;
   localparam logic [7:0] NIBBLE_LOW  = 8'h0F;
   localparam logic [7:0] NIBBLE_HIGH = 8'hF0;

   // queue between parser and output side
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_buffer;
   } nscs_req_type;

   typedef struct packed {
      logic       kind;
      logic [4:0] field_index;
      logic [6:0] field_start;
      logic [6:0] field_length;
      logic [1:0] status;
      logic [5:0] fields_found;
      logic [7:0] talker_first;
      logic [7:0] talker_second;
      logic       proprietary;
      logic       had_checksum;
      logic [7:0] computed_checksum;
      logic       last;
   } nscs_rsp_type;

   // everything one byte produces
   typedef struct packed {
      logic         has_desc;
      logic         has_verdict;
      nscs_rsp_type desc;
      nscs_rsp_type verdict;
   } nscs_step_type;

   // uppercase hex character of a nibble
   function automatic logic [7:0] nscs_hex_digit(input logic [3:0] v);
      logic [7:0] wide;
      wide = {4'd0, v};
      if (v < 4'd10) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_A + (wide - 8'd10);
   endfunction

endpackage

FILE: design/nmea_sentence_checker_splitter_top.sv
// channel   direction  handshake                  payload
// req       in         push / full                data_byte, first_of_buffer
// rsp       out        empty / pop                field descriptor or sentence verdict
//
// one byte is accepted per cycle while the step queue has room
// a byte that closes a field and ends the sentence yields two results, two pops
// the step queue holds 4 bytes' worth of results; full rises when it is filled
// results are registered in the step queue and show once the steps ahead of them are popped
// synchronous reset empties the queue and returns the parser to hunting for '$'
module nmea_sentence_checker_splitter_top
   import nscs_pkg::*;
#(
   parameter int MAX_LEN    = 128,
   parameter int MAX_FIELDS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  nscs_req_type req_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output nscs_rsp_type rsp_data
);

   logic          accept;
   logic          step_push, step_valid, step_pop;
   nscs_step_type step_in, step_head;

   assign accept = req_push && !req_full;

   // parser
   nscs_front #(
      .MAX_LEN    (MAX_LEN),
      .MAX_FIELDS (MAX_FIELDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .step_push (step_push),
      .step_data (step_in)
   );

   // step queue
   nscs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (step_in),
      .full      (req_full),
      .pop       (step_pop),
      .not_empty (step_valid),
      .head      (step_head)
   );

   // result sequencer
   nscs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step_data  (step_head),
      .step_pop   (step_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: design/nscs_front.sv
module nscs_front
   import nscs_pkg::*;
#(
   parameter int MAX_LEN,
   parameter int MAX_FIELDS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  nscs_req_type  req_data,
   output logic          step_push,
   output nscs_step_type step_data
);

   localparam int OW_RAW = $clog2(MAX_LEN + 2);
   localparam int OW     = (OW_RAW > 7) ? OW_RAW : 7;
   localparam int FW_RAW = $clog2(MAX_FIELDS + 1);
   localparam int FW     = (FW_RAW > 6) ? FW_RAW : 6;

   nscs_phase_type phase_ff, phase_in;
   logic [7:0]     xor_ff, xor_in;
   logic [OW-1:0]  offset_ff, offset_in;
   logic [OW-1:0]  cfs_ff, cfs_in;
   logic [FW-1:0]  fields_ff, fields_in;
   logic           bad_ff, bad_in;
   logic [15:0]    talker_ff, talker_in;
   logic [1:0]     alen_ff, alen_in;
   logic           ovf_ff, ovf_in;
   logic           mism_ff, mism_in;

   // state as seen by this byte, after a buffer restart
   nscs_phase_type phase_cur;
   logic [7:0]     xor_cur;
   logic [OW-1:0]  off, cfs_cur;
   logic [FW-1:0]  fields_cur;
   logic           bad_cur, ovf_cur, mism_cur;
   logic [15:0]    talker_cur;
   logic [1:0]     alen_cur;

   logic [7:0]     b;
   logic           is_dollar, is_star, is_term, is_comma, is_bad, at_limit;
   logic           close_req, verd_req, had, desc_ok;
   logic [OW-1:0]  close_end, len;
   logic [7:0]     t1, t2;
   logic           prop;
   logic [1:0]     status;

   assign b = req_data.data_byte;

   // restart on a new buffer
   always_comb begin
      if (req_data.first_of_buffer) begin
         phase_cur  = PH_HUNT;
         off        = '0;
         xor_cur    = '0;
         cfs_cur    = '0;
         fields_cur = '0;
         bad_cur    = 1'b0;
         talker_cur = '0;
         alen_cur   = '0;
         ovf_cur    = 1'b0;
         mism_cur   = 1'b0;
      end else begin
         phase_cur  = phase_ff;
         off        = offset_ff;
         xor_cur    = xor_ff;
         cfs_cur    = cfs_ff;
         fields_cur = fields_ff;
         bad_cur    = bad_ff;
         talker_cur = talker_ff;
         alen_cur   = alen_ff;
         ovf_cur    = ovf_ff;
         mism_cur   = mism_ff;
      end
   end

   // byte classification
   assign is_dollar = (b == CHAR_DOLLAR);
   assign is_star   = (b == CHAR_STAR);
   assign is_term   = (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL);
   assign is_comma  = (b == CHAR_COMMA);
   assign is_bad    = (b < PRINT_LOW) || (b > PRINT_HIGH);
   assign at_limit  = (off >= OW'(MAX_LEN - 1));

   // next state and results
   always_comb begin
      phase_in  = phase_cur;
      xor_in    = xor_cur;
      cfs_in    = cfs_cur;
      fields_in = fields_cur;
      bad_in    = bad_cur;
      talker_in = talker_cur;
      alen_in   = alen_cur;
      ovf_in    = ovf_cur;
      mism_in   = mism_cur;
      close_req = 1'b0;
      close_end = off;
      verd_req  = 1'b0;
      had       = 1'b0;

      case (phase_cur)
         PH_CHK_HI: begin
            if (b != nscs_hex_digit(4'((xor_cur & NIBBLE_HIGH) >> 4))) begin
               mism_in = 1'b1;
            end
            phase_in = PH_CHK_LO;
         end
         PH_CHK_LO: begin
            if (b != nscs_hex_digit(4'(xor_cur & NIBBLE_LOW))) begin
               mism_in = 1'b1;
            end
            verd_req = 1'b1;
            had      = 1'b1;
         end
         default: begin
            if (is_dollar) begin
               xor_in    = '0;
               cfs_in    = off + OW'(1);
               fields_in = '0;
               bad_in    = 1'b0;
               talker_in = '0;
               alen_in   = '0;
               ovf_in    = 1'b0;
               mism_in   = 1'b0;
               phase_in  = PH_SENT;
            end else if (phase_cur == PH_SENT) begin
               if (is_star) begin
                  close_req = 1'b1;
                  phase_in  = PH_CHK_HI;
               end else if (is_term) begin
                  close_req = 1'b1;
                  verd_req  = 1'b1;
               end else begin
                  xor_in = xor_cur ^ b;
                  if (is_bad) begin
                     bad_in = 1'b1;
                  end
                  if (is_comma) begin
                     close_req = 1'b1;
                     cfs_in    = off + OW'(1);
                  end else if (fields_cur == '0 && alen_cur < 2'd2) begin
                     if (alen_cur == 2'd0) begin
                        talker_in[7:0] = b;
                     end else begin
                        talker_in[15:8] = b;
                     end
                     alen_in = alen_cur + 2'd1;
                  end
                  if (at_limit) begin
                     if (!is_comma) begin
                        close_req = 1'b1;
                        close_end = off + OW'(1);
                     end
                     verd_req = 1'b1;
                  end
               end
            end
         end
      endcase

      // field close, dropped once the field limit is reached
      desc_ok = 1'b0;
      if (close_req) begin
         if (fields_cur >= FW'(MAX_FIELDS)) begin
            ovf_in = 1'b1;
         end else begin
            desc_ok   = 1'b1;
            fields_in = fields_cur + FW'(1);
         end
      end

      if (verd_req) begin
         phase_in = PH_HUNT;
      end
   end

   assign len = (close_end >= cfs_cur) ? (close_end - cfs_cur) : '0;

   // talker and status for the verdict
   always_comb begin
      t1 = (alen_in >= 2'd1) ? talker_in[7:0] : 8'd0;
      t2 = (alen_in >= 2'd2) ? talker_in[15:8] : 8'd0;
      prop = (t1 == CHAR_P);
      if (prop) begin
         t2 = 8'd0;
      end
      if (bad_in) begin
         status = STATUS_NONPRINT;
      end else if (had && mism_in) begin
         status = STATUS_MISMATCH;
      end else if (ovf_in) begin
         status = STATUS_OVERFLOW;
      end else begin
         status = STATUS_OK;
      end
   end

   // descriptor and verdict payload
   always_comb begin
      step_data                           = '0;
      step_data.has_desc                  = desc_ok;
      step_data.desc.kind                 = KIND_FIELD;
      step_data.desc.field_index          = fields_cur[4:0];
      step_data.desc.field_start          = cfs_cur[6:0];
      step_data.desc.field_length         = len[6:0];
      step_data.desc.last                 = !verd_req;
      step_data.has_verdict               = verd_req;
      step_data.verdict.kind              = KIND_VERDICT;
      step_data.verdict.status            = status;
      step_data.verdict.fields_found      = fields_in[5:0];
      step_data.verdict.talker_first      = t1;
      step_data.verdict.talker_second     = t2;
      step_data.verdict.proprietary       = prop;
      step_data.verdict.had_checksum      = had;
      step_data.verdict.computed_checksum = xor_in;
      step_data.verdict.last              = 1'b1;
   end

   // only steps with results enter the queue
   assign step_push = accept && (desc_ok || verd_req);

   // saturating byte offset
   assign offset_in = (off < OW'(MAX_LEN)) ? off + OW'(1) : off;

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         xor_ff    <= '0;
         offset_ff <= '0;
         cfs_ff    <= '0;
         fields_ff <= '0;
         bad_ff    <= 1'b0;
         talker_ff <= '0;
         alen_ff   <= '0;
         ovf_ff    <= 1'b0;
         mism_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         xor_ff    <= xor_in;
         offset_ff <= offset_in;
         cfs_ff    <= cfs_in;
         fields_ff <= fields_in;
         bad_ff    <= bad_in;
         talker_ff <= talker_in;
         alen_ff   <= alen_in;
         ovf_ff    <= ovf_in;
         mism_ff   <= mism_in;
      end
   end

endmodule

FILE: design/nscs_fifo.sv
module nscs_fifo
   import nscs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  nscs_step_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output nscs_step_type head
);

   nscs_step_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/nscs_back.sv
module nscs_back
   import nscs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step_valid,
   input  nscs_step_type step_data,
   output logic          step_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output nscs_rsp_type  rsp_data
);

   logic desc_done_ff, desc_done_in;
   logic show_desc, taken;

   // descriptor goes out first, verdict after it
   assign show_desc = step_data.has_desc && !desc_done_ff;
   assign rsp_data  = show_desc ? step_data.desc : step_data.verdict;
   assign rsp_empty = !step_valid;
   assign taken     = rsp_pop && step_valid;
   assign step_pop  = taken && !(show_desc && step_data.has_verdict);

   // remember a delivered descriptor while its verdict waits
   always_comb begin
      desc_done_in = desc_done_ff;
      if (taken) begin
         desc_done_in = show_desc && step_data.has_verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_done_ff <= 1'b0;
      end else begin
         desc_done_ff <= desc_done_in;
      end
   end

endmodule

FILE: design/nscs_checker.sv
module nscs_checker
   import nscs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_push,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input nscs_rsp_type rsp_data
);

   // queue comes up empty and open after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   // no result appears without an input transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_empty && !(req_push && !req_full) |=> rsp_empty)
      else $error("result without input transaction");

   // a descriptor not marked last is followed by its verdict
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_data.kind == KIND_FIELD && !rsp_data.last
      |=> !rsp_empty && rsp_data.kind == KIND_VERDICT)
      else $error("verdict missing after descriptor");

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed while waiting");

endmodule

bind nmea_sentence_checker_splitter_top nscs_checker u_nscs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

FILE: bench/tb_nmea_sentence_checker_splitter_top.sv
module tb_nmea_sentence_checker_splitter_top;
   import nscs_pkg::*;

   localparam int LEN_LIMIT     = 128;
   localparam int FIELD_LIMIT   = 32;
   localparam int STREAM_TARGET = 550;
   localparam int CALM_TAIL     = 60;

   // sentence shapes for the stream builder
   typedef enum int {
      SH_GOOD,
      SH_BARE,
      SH_BAD_SUM,
      SH_NONPRINT,
      SH_MANY,
      SH_LONG,
      SH_REDOLLAR,
      SH_RESTART,
      SH_NOISE
   } shape_type;

   typedef struct packed {
      logic         drain;
      nscs_req_type req;
   } byte_slot_type;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   nscs_req_type req_data;
   logic         rsp_empty;
   logic         rsp_pop;
   nscs_rsp_type rsp_data;

   // parser shadow state
   nscs_phase_type parse_phase;
   logic [7:0]     sum_xor;
   logic [7:0]     stream_off;
   logic [7:0]     field_begin;
   logic [5:0]     field_total;
   logic           bad_seen;
   logic           over_seen;
   logic           digit_bad;
   logic [15:0]    talker;
   logic [1:0]     addr_len;

   nscs_rsp_type  step_out[$];
   nscs_rsp_type  expected_rsp[$];
   byte_slot_type pending[$];

   // stream builder state
   logic       next_fob;
   logic       next_drain;
   logic       counting;
   logic [7:0] build_xor;
   int         stream_items;
   int         sentences_built;

   int mismatches;
   int bytes_sent;
   int fields_checked;
   int verdicts_checked;
   int send_gap;
   int stall_gap;

   nmea_sentence_checker_splitter_top #(
      .MAX_LEN   (LEN_LIMIT),
      .MAX_FIELDS(FIELD_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // uppercase hex character of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return CHAR_ZERO + {4'd0, v};
      end
      return CHAR_A + {4'd0, v} - 8'd10;
   endfunction

   task automatic clear_sentence();
      sum_xor     = '0;
      field_begin = '0;
      field_total = '0;
      bad_seen    = 1'b0;
      over_seen   = 1'b0;
      digit_bad   = 1'b0;
      talker      = '0;
      addr_len    = '0;
   endtask

   // descriptor for the field that ends at end_off, unless the field table is full
   task automatic close_field(input logic [8:0] end_off);
      nscs_rsp_type r;
      logic [8:0]   len;
      len = (end_off >= {1'b0, field_begin}) ? end_off - {1'b0, field_begin} : 9'd0;
      if (field_total >= FIELD_LIMIT) begin
         over_seen = 1'b1;
      end else begin
         r              = '0;
         r.kind         = KIND_FIELD;
         r.field_index  = field_total[4:0];
         r.field_start  = field_begin[6:0];
         r.field_length = len[6:0];
         step_out.push_back(r);
         field_total++;
      end
   endtask

   task automatic emit_verdict(input logic had);
      nscs_rsp_type r;
      logic [7:0]   t1;
      logic [7:0]   t2;
      r  = '0;
      t1 = (addr_len >= 2'd1) ? talker[7:0] : 8'd0;
      t2 = (addr_len >= 2'd2) ? talker[15:8] : 8'd0;
      if (t1 == CHAR_P) begin
         r.proprietary = 1'b1;
         t2 = 8'd0;
      end
      if (bad_seen) begin
         r.status = STATUS_NONPRINT;
      end else if (had && digit_bad) begin
         r.status = STATUS_MISMATCH;
      end else if (over_seen) begin
         r.status = STATUS_OVERFLOW;
      end else begin
         r.status = STATUS_OK;
      end
      r.kind              = KIND_VERDICT;
      r.fields_found      = field_total;
      r.talker_first      = t1;
      r.talker_second     = t2;
      r.had_checksum      = had;
      r.computed_checksum = sum_xor;
      step_out.push_back(r);
      parse_phase = PH_HUNT;
   endtask

   // advance the shadow parser by one accepted byte and queue what it yields
   task automatic parse_byte(input nscs_req_type r);
      logic [7:0]   b;
      logic [8:0]   off;
      nscs_rsp_type tail;
      b = r.data_byte;
      step_out.delete();
      if (r.first_of_buffer) begin
         parse_phase = PH_HUNT;
         stream_off  = '0;
         clear_sentence();
      end
      off = {1'b0, stream_off};
      if (parse_phase == PH_CHK_HI) begin
         if (b != hex_char(sum_xor[7:4])) digit_bad = 1'b1;
         parse_phase = PH_CHK_LO;
      end else if (parse_phase == PH_CHK_LO) begin
         if (b != hex_char(sum_xor[3:0])) digit_bad = 1'b1;
         emit_verdict(1'b1);
      end else if (b == CHAR_DOLLAR) begin
         clear_sentence();
         field_begin = off[7:0] + 8'd1;
         parse_phase = PH_SENT;
      end else if (parse_phase == PH_SENT) begin
         if (b == CHAR_STAR) begin
            close_field(off);
            parse_phase = PH_CHK_HI;
         end else if (b == CHAR_CR || b == CHAR_LF || b == CHAR_NUL) begin
            close_field(off);
            emit_verdict(1'b0);
         end else begin
            sum_xor ^= b;
            if (b < PRINT_LOW || b > PRINT_HIGH) bad_seen = 1'b1;
            if (b == CHAR_COMMA) begin
               close_field(off);
               field_begin = off[7:0] + 8'd1;
            end else if (field_total == 6'd0 && addr_len < 2'd2) begin
               if (addr_len == 2'd0) talker[7:0] = b;
               else talker[15:8] = b;
               addr_len++;
            end
            // length limit ends the sentence on this byte
            if (off >= LEN_LIMIT - 1) begin
               if (b != CHAR_COMMA) close_field(off + 9'd1);
               emit_verdict(1'b0);
            end
         end
      end
      if (stream_off < LEN_LIMIT) stream_off++;
      if (step_out.size() > 0) begin
         tail = step_out.pop_back();
         tail.last = 1'b1;
         step_out.push_back(tail);
      end
      foreach (step_out[i]) expected_rsp.push_back(step_out[i]);
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t:%s", $time, msg);
   endtask

   function automatic string field_diff(input string name, input int e, input int g);
      if (e == g) return "";
      return $sformatf(" %s exp %0d got %0d", name, e, g);
   endfunction

   task automatic check_result(input nscs_rsp_type got);
      nscs_rsp_type e;
      string        msg;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf(" result with nothing expected %h", got));
      end else begin
         e = expected_rsp.pop_front();
         if (e.kind == KIND_VERDICT) verdicts_checked++;
         else fields_checked++;
         if ((^got) === 1'bx) begin
            report_mismatch($sformatf(" unknown bits in result %h, exp %h", got, e));
         end else begin
            msg = "";
            msg = {msg, field_diff("kind", e.kind, got.kind)};
            msg = {msg, field_diff("field_index", e.field_index, got.field_index)};
            msg = {msg, field_diff("field_start", e.field_start, got.field_start)};
            msg = {msg, field_diff("field_length", e.field_length, got.field_length)};
            msg = {msg, field_diff("status", e.status, got.status)};
            msg = {msg, field_diff("fields_found", e.fields_found, got.fields_found)};
            msg = {msg, field_diff("talker_first", e.talker_first, got.talker_first)};
            msg = {msg, field_diff("talker_second", e.talker_second, got.talker_second)};
            msg = {msg, field_diff("proprietary", e.proprietary, got.proprietary)};
            msg = {msg, field_diff("had_checksum", e.had_checksum, got.had_checksum)};
            msg = {msg, field_diff("computed_checksum", e.computed_checksum,
                                   got.computed_checksum)};
            msg = {msg, field_diff("last", e.last, got.last)};
            if (msg != "") report_mismatch(msg);
         end
      end
   endtask

   // stream building
   task automatic add_byte(input logic [7:0] b);
      byte_slot_type slot;
      slot.req.data_byte       = b;
      slot.req.first_of_buffer = next_fob;
      slot.drain               = next_drain;
      next_fob   = 1'b0;
      next_drain = 1'b0;
      pending.push_back(slot);
      if (counting) stream_items++;
   endtask

   task automatic add_content(input logic [7:0] c);
      add_byte(c);
      build_xor ^= c;
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(32, 126));
      end while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_COMMA);
      return c;
   endfunction

   // control byte or high byte that does not end a sentence
   function automatic logic [7:0] bad_char();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) begin
         do begin
            c = 8'($urandom_range(1, 31));
         end while (c == CHAR_LF || c == CHAR_CR);
      end else begin
         c = 8'($urandom_range(127, 255));
      end
      return c;
   endfunction

   task automatic build_sentence(input shape_type shape);
      int         alen;
      int         nfields;
      int         flen;
      int         cut;
      int         pick;
      logic       use_star;
      logic [7:0] hi;
      logic [7:0] lo;
      sentences_built++;
      if ($urandom_range(0, 19) == 0) next_drain = 1'b1;
      // random junk with random buffer restarts
      if (shape == SH_NOISE) begin
         counting = 1'b0;
         repeat ($urandom_range(3, 10)) begin
            next_fob = ($urandom_range(0, 3) == 0);
            add_byte(8'($urandom_range(0, 255)));
         end
         counting = 1'b1;
         return;
      end
      next_fob  = ($urandom_range(0, 4) != 0) || shape == SH_LONG;
      build_xor = 8'h00;
      if (shape != SH_LONG) begin
         repeat ($urandom_range(0, 2)) add_byte(plain_char());
      end
      add_byte(CHAR_DOLLAR);
      // address field, sometimes proprietary
      alen = $urandom_range(0, 6);
      for (int i = 0; i < alen; i++) begin
         if (i == 0 && $urandom_range(0, 3) == 0) add_content(CHAR_P);
         else add_content(8'($urandom_range(65, 90)));
      end
      case (shape)
         SH_MANY: nfields = $urandom_range(33, 40);
         SH_LONG: nfields = $urandom_range(15, 20);
         default: nfields = $urandom_range(1, 8);
      endcase
      cut = $urandom_range(1, nfields);
      for (int f = 1; f <= nfields; f++) begin
         if (f == cut) begin
            case (shape)
               SH_NONPRINT: add_content(bad_char());
               SH_REDOLLAR: begin
                  add_byte(CHAR_DOLLAR);
                  build_xor = 8'h00;
               end
               SH_RESTART: begin
                  next_fob = 1'b1;
                  if ($urandom_range(0, 1) == 0) begin
                     add_byte(CHAR_DOLLAR);
                     build_xor = 8'h00;
                  end
               end
               default: ;
            endcase
         end
         add_content(CHAR_COMMA);
         case (shape)
            SH_MANY: flen = $urandom_range(0, 2);
            SH_LONG: flen = $urandom_range(8, 12);
            default: flen = $urandom_range(0, 6);
         endcase
         repeat (flen) add_content(plain_char());
      end
      // terminator, checksum suffix or end of line
      case (shape)
         SH_GOOD, SH_BAD_SUM, SH_REDOLLAR: use_star = 1'b1;
         SH_BARE:                          use_star = 1'b0;
         default:                          use_star = $urandom_range(0, 1);
      endcase
      if (use_star) begin
         add_byte(CHAR_STAR);
         hi = hex_char(build_xor[7:4]);
         lo = hex_char(build_xor[3:0]);
         if (shape == SH_BAD_SUM) begin
            pick = $urandom_range(0, 3);
            case (pick)
               0: hi = hex_char(build_xor[7:4] ^ 4'($urandom_range(1, 15)));
               1: lo = hex_char(build_xor[3:0] ^ 4'($urandom_range(1, 15)));
               2: begin
                  hi = 8'($urandom_range(0, 255));
                  lo = 8'($urandom_range(0, 255));
               end
               default: lo = lo | 8'h20;
            endcase
         end
         add_byte(hi);
         add_byte(lo);
         if ($urandom_range(0, 1) == 0) begin
            add_byte(CHAR_CR);
            add_byte(CHAR_LF);
         end
      end else begin
         pick = $urandom_range(0, 2);
         case (pick)
            0:       add_byte(CHAR_CR);
            1:       add_byte(CHAR_LF);
            default: add_byte(CHAR_NUL);
         endcase
      end
   endtask

   function automatic shape_type random_shape();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return SH_GOOD;
      if (roll < 45) return SH_BARE;
      if (roll < 57) return SH_BAD_SUM;
      if (roll < 67) return SH_NONPRINT;
      if (roll < 72) return SH_MANY;
      if (roll < 76) return SH_LONG;
      if (roll < 84) return SH_REDOLLAR;
      if (roll < 92) return SH_RESTART;
      return SH_NOISE;
   endfunction

   // driver: offers the oldest pending byte, runs the shadow parser on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            parse_byte(req_data);
            void'(pending.pop_front());
            bytes_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending.size() == 0) begin
            req_push <= 1'b0;
         end else if (pending[0].drain && expected_rsp.size() != 0) begin
            req_push <= 1'b0;
         end else if (pending.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_data <= pending[0].req;
         end
      end
   end

   // monitor: pops results with random stalls and checks each transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_pop <= 1'b0;
         end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            stall_gap = $urandom_range(1, 11) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      #4000000;
      $display("timeout: %0d bytes pending, %0d results outstanding",
               pending.size(), expected_rsp.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_push         = 1'b0;
      req_data         = '0;
      rsp_pop          = 1'b0;
      parse_phase      = PH_HUNT;
      stream_off       = '0;
      next_fob         = 1'b0;
      next_drain       = 1'b0;
      counting         = 1'b1;
      build_xor        = '0;
      stream_items     = 0;
      sentences_built  = 0;
      mismatches       = 0;
      bytes_sent       = 0;
      fields_checked   = 0;
      verdicts_checked = 0;
      clear_sentence();

      // directed: junk at the byte extremes, ignored before any dollar
      next_fob = 1'b1;
      add_byte(CHAR_NUL);
      add_byte(8'hFF);
      add_byte(CHAR_A);
      // two empty fields after the address, correct checksum
      build_xor = 8'h00;
      add_byte(CHAR_DOLLAR);
      add_content(8'h47);
      add_content(CHAR_P);
      add_content(CHAR_COMMA);
      add_content(CHAR_COMMA);
      add_byte(CHAR_STAR);
      add_byte(hex_char(build_xor[7:4]));
      add_byte(hex_char(build_xor[3:0]));
      // repeated dollar, proprietary address, delete char, ended by cr
      add_byte(CHAR_DOLLAR);
      add_byte(8'h58);
      add_byte(CHAR_DOLLAR);
      add_byte(CHAR_P);
      add_byte(8'h51);
      add_byte(8'h7F);
      add_byte(CHAR_CR);
      // buffer restart drops the open sentence
      add_byte(CHAR_DOLLAR);
      add_byte(CHAR_A);
      next_fob = 1'b1;
      add_byte(8'h42);
      // empty address field closed by lf
      add_byte(CHAR_DOLLAR);
      add_byte(CHAR_LF);

      // random: every shape once, then a weighted mix
      next_drain = 1'b1;
      for (int s = 0; s <= SH_NOISE; s++) build_sentence(shape_type'(s));
      while (stream_items < STREAM_TARGET) build_sentence(random_shape());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d bytes sent in %0d generated sentences and noise runs",
               bytes_sent, sentences_built);
      $display("%0d field descriptors and %0d verdicts compared, %0d mismatches",
               fields_checked, verdicts_checked, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/nscs_pkg.sv
design/nscs_front.sv
design/nscs_fifo.sv
design/nscs_back.sv
design/nmea_sentence_checker_splitter_top.sv
design/nscs_checker.sv
bench/tb_nmea_sentence_checker_splitter_top.sv
